[src/rifc_pkg.sv]
// Package: sizes, op codes and helpers for the routing information cache
`default_nettype none
package rifc_pkg;
    localparam int BUCKETS = 16;
    localparam int WAYS = 4;
    localparam int SLOTS = BUCKETS * WAYS;
    localparam int BKT_W = $clog2(BUCKETS);
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOT_W = $clog2(SLOTS);

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_LEARN  = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_SWEEP  = 2'd3;

    localparam logic [15:0] LEN_BITS     = 16'h1F00;
    localparam logic [15:0] DIR_BIT      = 16'h0080;
    localparam logic [15:0] TYPE_BITS    = 16'hC000;
    localparam logic [15:0] EXPLORER_RCF = 16'hC220;
    localparam logic [15:0] KEEP_BITS    = 16'h1FFF;

    localparam logic CFG_AGE_LIMIT = 1'b0;
    localparam logic CFG_BROADCAST = 1'b1;

    typedef struct packed {
        logic [47:0] station;
        logic [15:0] control;
        logic [63:0] route_high;
        logic [63:0] route_low;
        logic [31:0] stamp;
    } entry_t;

    typedef struct packed {
        logic         we;
        logic [SLOT_W-1:0] addr;
        entry_t       data;
    } mem_wr_t;

    // Byte sum modulo the bucket count (power of two, so a mask).
    function automatic logic [BKT_W-1:0] bucket_of(input logic [47:0] a);
        logic [10:0] sum;
        sum = 11'd0;
        for (int b = 0; b < 6; b++)
        begin
            sum = sum + {3'd0, a[8*b +: 8]};
        end
        return sum[BKT_W-1:0];
    endfunction
endpackage
`default_nettype wire

[src/rifc_ram.sv]
// Entry memory: one write port, one read port, registered read data
`default_nettype none
module rifc_ram (
    input  wire logic                        clk,
    input  wire rifc_pkg::mem_wr_t           wr,
    input  wire logic [rifc_pkg::SLOT_W-1:0] rd_addr,
    output rifc_pkg::entry_t                 rd_data
);
    rifc_pkg::entry_t mem [rifc_pkg::SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

[src/source_route_info_cache_top.sv]
// Routing information cache: lookup and learn probe the bucket's ways in turn, a
// PROBE and a CHECK state per way, up to the first match; a broadcast lookup and a
// tick go straight to RESULT; a sweep walks every slot. Each way is read once
// through the single read port of the entry memory, so the ways are probed one at
// a time; the next item can be taken in the cycle after the result is taken.
// Reset clears valid bits, time and the FSM; entry contents are not cleared.
`default_nettype none
module source_route_info_cache_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [47:0]  cfg_data,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [1:0]   op,
    input  wire logic [47:0]  station,
    input  wire logic [15:0]  control_word,
    input  wire logic [63:0]  segments_high,
    input  wire logic [63:0]  segments_low,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic              route_present,
    output logic [15:0]       control_out,
    output logic [63:0]       segments_high_out,
    output logic [63:0]       segments_low_out,
    output logic              found
);
    localparam int SW = rifc_pkg::SLOT_W;
    localparam int WW = rifc_pkg::WAY_W;

    typedef enum logic [2:0] {IDLE, PROBE, CHECK, SWEEP, RESULT} state_t;

    state_t state_reg;
    logic [31:0] age_limit_reg, time_reg;
    logic [47:0] bcast_reg;
    logic [rifc_pkg::SLOTS-1:0] valid_reg;
    logic [1:0]  op_reg;
    logic [47:0] station_reg;
    logic [15:0] ctl_reg;
    logic [63:0] sh_reg, sl_reg;
    logic [SW-1:0] slot_reg, rd_addr;
    logic [WW:0] way_reg;
    logic free_hit_reg;
    logic [WW-1:0] free_way_reg;
    logic rp_reg, found_reg, out_valid_reg;
    logic [15:0] co_reg;
    logic [63:0] oh_reg, ol_reg;
    rifc_pkg::mem_wr_t wr;
    rifc_pkg::entry_t rd;

    rifc_ram u_ram (.clk(clk), .wr(wr), .rd_addr(rd_addr), .rd_data(rd));

    logic [rifc_pkg::BKT_W-1:0] bkt;
    logic [SW-1:0] probe_slot;
    logic last_way, slot_valid, match, idle_take;
    assign bkt = rifc_pkg::bucket_of(station_reg);
    assign probe_slot = SW'({bkt, way_reg[WW-1:0]});
    assign last_way = (way_reg == (WW+1)'(rifc_pkg::WAYS - 1));
    assign slot_valid = valid_reg[slot_reg];
    assign match = slot_valid && (rd.station == station_reg);
    assign in_ready = (state_reg == IDLE) && !out_valid_reg;
    assign idle_take = in_valid && in_ready;
    assign rd_addr = (state_reg == SWEEP) ? slot_reg : probe_slot;

    always_comb
    begin
        wr = '0;
        wr.data.station = station_reg;
        wr.data.control = ctl_reg;
        wr.data.route_high = sh_reg;
        wr.data.route_low = sl_reg;
        wr.data.stamp = time_reg;
        if (state_reg == CHECK && match)
        begin
            wr.addr = slot_reg;
            if (op_reg == rifc_pkg::OP_LOOKUP)
            begin
                wr.we = (rd.control & rifc_pkg::LEN_BITS) != 16'd0;
                wr.data = rd;
                wr.data.stamp = time_reg;
            end
            else
            begin
                wr.we = (rd.control != ctl_reg) &&
                        ((ctl_reg & rifc_pkg::TYPE_BITS) == 16'd0);
            end
        end
        else if (state_reg == CHECK && last_way && op_reg == rifc_pkg::OP_LEARN)
        begin
            wr.we = free_hit_reg || !slot_valid;
            wr.addr = SW'({bkt, (free_hit_reg ? free_way_reg : way_reg[WW-1:0])});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            age_limit_reg <= 32'd60000;
            bcast_reg <= '1;
            time_reg <= '0;
            valid_reg <= '0;
            out_valid_reg <= 1'b0;
            way_reg <= '0;
            slot_reg <= '0;
            free_hit_reg <= 1'b0;
            free_way_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == rifc_pkg::CFG_AGE_LIMIT)
                    age_limit_reg <= cfg_data[31:0];
                else
                    bcast_reg <= cfg_data;
            end
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (wr.we && !(state_reg == CHECK && match))
                valid_reg[wr.addr] <= 1'b1;
            case (state_reg)
                IDLE:
                begin
                    if (idle_take)
                    begin
                        op_reg <= op;
                        station_reg <= (op == rifc_pkg::OP_LEARN) ?
                                       {1'b0, station[46:0]} : station;
                        ctl_reg <= control_word;
                        sh_reg <= segments_high;
                        sl_reg <= segments_low;
                        rp_reg <= 1'b0; co_reg <= '0; oh_reg <= '0; ol_reg <= '0;
                        found_reg <= 1'b0;
                        way_reg <= '0;
                        slot_reg <= '0;
                        free_hit_reg <= 1'b0;
                        case (op)
                            rifc_pkg::OP_TICK:
                            begin
                                time_reg <= time_reg + 32'd1;
                                state_reg <= RESULT;
                            end
                            rifc_pkg::OP_SWEEP: state_reg <= SWEEP;
                            rifc_pkg::OP_LOOKUP:
                            begin
                                if (station == bcast_reg)
                                begin
                                    rp_reg <= 1'b1;
                                    co_reg <= rifc_pkg::EXPLORER_RCF;
                                    state_reg <= RESULT;
                                end
                                else
                                    state_reg <= PROBE;
                            end
                            default: state_reg <= PROBE;
                        endcase
                    end
                end
                PROBE:
                begin
                    // read issued this cycle, compare next
                    slot_reg <= probe_slot;
                    state_reg <= CHECK;
                end
                CHECK:
                begin
                    if (!slot_valid && !free_hit_reg)
                    begin
                        free_hit_reg <= 1'b1;
                        free_way_reg <= way_reg[WW-1:0];
                    end
                    if (match)
                    begin
                        found_reg <= 1'b1;
                        if (op_reg == rifc_pkg::OP_LOOKUP &&
                            (rd.control & rifc_pkg::LEN_BITS) != 16'd0)
                        begin
                            rp_reg <= 1'b1;
                            co_reg <= (rd.control ^ rifc_pkg::DIR_BIT) &
                                      rifc_pkg::KEEP_BITS;
                            oh_reg <= rd.route_high;
                            ol_reg <= rd.route_low;
                        end
                        state_reg <= RESULT;
                    end
                    else if (last_way)
                    begin
                        if (op_reg == rifc_pkg::OP_LOOKUP)
                        begin
                            rp_reg <= 1'b1;
                            co_reg <= rifc_pkg::EXPLORER_RCF;
                        end
                        state_reg <= RESULT;
                    end
                    else
                    begin
                        way_reg <= way_reg + (WW+1)'(1);
                        state_reg <= PROBE;
                    end
                end
                SWEEP:
                begin
                    // stamp of slot_reg-1 arrives while slot_reg is read
                    if (way_reg[0] &&
                        (time_reg - rd.stamp) > age_limit_reg)
                        valid_reg[SW'(slot_reg - SW'(1))] <= 1'b0;
                    way_reg[0] <= 1'b1;
                    if (way_reg[0] && slot_reg == '0)
                        state_reg <= RESULT;
                    else
                        slot_reg <= slot_reg + SW'(1);
                end
                RESULT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg <= IDLE;
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign route_present = rp_reg;
    assign control_out = co_reg;
    assign segments_high_out = oh_reg;
    assign segments_low_out = ol_reg;
    assign found = found_reg;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid) else $error("ready while result pending");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == RESULT) |=> out_valid) else $error("result lost");
    a_explorer: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !route_present) |-> (control_out == 16'd0))
        else $error("control without route");
    a_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (idle_take && op == rifc_pkg::OP_TICK) |=> time_reg == $past(time_reg) + 32'd1)
        else $error("tick missed");
`endif
endmodule
`default_nettype wire
